// File: src/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

  localparam int IDX_W   = 48;
  localparam int CNT_W   = 11;
  localparam int CRC_W   = 32;
  localparam int GAP_W   = 32;
  localparam int STAT_W  = 3;
  localparam int DIGIT_W = 8;
  localparam int NDIG    = IDX_W / DIGIT_W;

  localparam int MAX_PAIRS_DEF  = 1024;
  localparam int BYTES_PER_PAIR = 4;
  localparam int PAIR_SHIFT     = $clog2(BYTES_PER_PAIR);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

  localparam logic [STAT_W-1:0] ST_ACCEPT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_GAP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BACKWARD = 3'd2;
  localparam logic [STAT_W-1:0] ST_END_OK   = 3'd3;
  localparam logic [STAT_W-1:0] ST_END_BAD  = 3'd4;
  localparam logic [STAT_W-1:0] ST_REJECT   = 3'd5;

  // Outcome of the digit-serial index compare.
  typedef struct packed {
    logic done;
    logic below;
    logic ahead;
  } idx_res_t;

  // Advances a reflected CRC-32 register over one zero byte.
  function automatic logic [CRC_W-1:0] crc_zero_byte(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] t;
    t = v;
    for (int i = 0; i < 8; i++) begin
      t = (t >> 1) ^ (t[0] ? CRC_POLY : '0);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: src/rsc_idx_serial.sv
`default_nettype none

// Digit-serial subtract and add over the 48-bit index: one digit per cycle,
// least significant first.
module rsc_idx_serial (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rsc_pkg::IDX_W-1:0] a_in,
  input  wire logic [rsc_pkg::IDX_W-1:0] b_in,
  input  wire logic [rsc_pkg::CNT_W-1:0] c_in,
  output rsc_pkg::idx_res_t              res,
  output logic      [rsc_pkg::IDX_W-1:0] diff,
  output logic      [rsc_pkg::IDX_W-1:0] sum
);
  import rsc_pkg::*;

  localparam int DCNT_W = $clog2(NDIG + 1);
  localparam logic [DCNT_W-1:0] LAST = DCNT_W'(NDIG);

  logic [IDX_W-1:0]   a_r, b_r, c_r, diff_r, sum_r;
  logic [IDX_W-1:0]   a_nxt, b_nxt, c_nxt, diff_nxt, sum_nxt;
  logic               borrow_r, borrow_nxt, carry_r, carry_nxt, nz_r, nz_nxt;
  logic               run_r, run_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [DIGIT_W:0]   d_sub, d_add;
  logic               busy;

  assign busy = run_r && (dcnt_r != LAST);

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    diff_nxt   = diff_r;
    sum_nxt    = sum_r;
    borrow_nxt = borrow_r;
    carry_nxt  = carry_r;
    nz_nxt     = nz_r;
    run_nxt    = run_r;
    dcnt_nxt   = dcnt_r;
    d_sub = {1'b0, a_r[DIGIT_W-1:0]} - {1'b0, b_r[DIGIT_W-1:0]}
            - {{DIGIT_W{1'b0}}, borrow_r};
    d_add = {1'b0, a_r[DIGIT_W-1:0]} + {1'b0, c_r[DIGIT_W-1:0]}
            + {{DIGIT_W{1'b0}}, carry_r};
    if (start) begin
      a_nxt      = a_in;
      b_nxt      = b_in;
      c_nxt      = IDX_W'(c_in);
      borrow_nxt = 1'b0;
      carry_nxt  = 1'b0;
      nz_nxt     = 1'b0;
      run_nxt    = 1'b1;
      dcnt_nxt   = '0;
    end else if (busy) begin
      a_nxt      = a_r >> DIGIT_W;
      b_nxt      = b_r >> DIGIT_W;
      c_nxt      = c_r >> DIGIT_W;
      diff_nxt   = {d_sub[DIGIT_W-1:0], diff_r[IDX_W-1:DIGIT_W]};
      sum_nxt    = {d_add[DIGIT_W-1:0], sum_r[IDX_W-1:DIGIT_W]};
      borrow_nxt = d_sub[DIGIT_W];
      carry_nxt  = d_add[DIGIT_W];
      nz_nxt     = nz_r | (|d_sub[DIGIT_W-1:0]);
      dcnt_nxt   = dcnt_r + 1'b1;
    end else if (run_r) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      dcnt_r <= '0;
    end else begin
      run_r  <= run_nxt;
      dcnt_r <= dcnt_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    diff_r   <= diff_nxt;
    sum_r    <= sum_nxt;
    borrow_r <= borrow_nxt;
    carry_r  <= carry_nxt;
    nz_r     <= nz_nxt;
  end

  assign res  = {run_r && (dcnt_r == LAST), borrow_r, nz_r && !borrow_r};
  assign diff = diff_r;
  assign sum  = sum_r;

endmodule

`default_nettype wire

// File: src/rsc_crc_shift.sv
`default_nettype none

// Moves a CRC-32 register forward over a run of zero bytes, one byte per cycle.
module rsc_crc_shift #(
  parameter int BYTE_W = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rsc_pkg::CRC_W-1:0] crc_in,
  input  wire logic [BYTE_W-1:0]         nbytes,
  output logic                           done,
  output logic      [rsc_pkg::CRC_W-1:0] crc_out
);
  import rsc_pkg::*;

  logic [CRC_W-1:0]  v_r, v_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic              run_r, run_nxt;

  always_comb begin
    v_nxt    = v_r;
    left_nxt = left_r;
    run_nxt  = run_r;
    if (start) begin
      v_nxt    = crc_in;
      left_nxt = nbytes;
      run_nxt  = 1'b1;
    end else if (run_r && (left_r != '0)) begin
      v_nxt    = crc_zero_byte(v_r);
      left_nxt = left_r - 1'b1;
    end else if (run_r) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      left_r <= '0;
    end else begin
      run_r  <= run_nxt;
      left_r <= left_nxt;
    end
    v_r <= v_nxt;
  end

  assign done    = run_r && (left_r == '0);
  assign crc_out = v_r;

endmodule

`default_nettype wire

// File: src/record_sequence_checker.sv
`default_nettype none

// Record sequence checker. Takes one record header per request and returns one
// result: continuity status, zero pairs to fill for a gap, the running stream
// CRC-32, the next expected index and the saturating gap count. A data record
// goes through a digit-serial pass over the 48-bit index and then the CRC
// combine, which advances the running CRC over the record's zero bytes one byte
// per cycle; an end record takes only the index pass, and a rejected request
// takes neither. The next request is taken once the result has moved to the
// output registers. A new request is taken while the previous result waits on
// a stalled output.
module record_sequence_checker #(
  parameter int MAX_PAIRS = rsc_pkg::MAX_PAIRS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rsc_pkg::IDX_W-1:0]  in_record_index,
  input  wire logic [rsc_pkg::CNT_W-1:0]  in_pair_count,
  input  wire logic [rsc_pkg::CRC_W-1:0]  in_record_crc,
  input  wire logic                       in_is_end,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [rsc_pkg::STAT_W-1:0] out_status,
  output logic      [rsc_pkg::IDX_W-1:0]  out_fill_pairs,
  output logic      [rsc_pkg::CRC_W-1:0]  out_stream_crc,
  output logic      [rsc_pkg::IDX_W-1:0]  out_next_index,
  output logic      [rsc_pkg::GAP_W-1:0]  out_gap_total
);
  import rsc_pkg::*;

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CAP     = (MAX_PAIRS < CNT_MAX) ? MAX_PAIRS : CNT_MAX;
  localparam int BYTE_W  = $clog2(CAP * BYTES_PER_PAIR + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IDX  = 2'd1;
  localparam logic [1:0] S_CRC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  exp_r, exp_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic              seen_r, seen_nxt, closed_r, closed_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CRC_W-1:0]  rcrc_r, rcrc_nxt;
  logic              end_r, end_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_fill_r, res_fill_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_fill_r, out_fill_nxt, out_next_r, out_next_nxt;
  logic [CRC_W-1:0]  out_crc_r, out_crc_nxt;
  logic [GAP_W-1:0]  out_gap_r, out_gap_nxt;

  logic              accept, oversized, idx_start, crc_start, crc_done;
  logic [IDX_W-1:0]  idx_base, idx_diff, idx_sum;
  logic [CRC_W-1:0]  crc_shifted;
  logic [BYTE_W-1:0] crc_bytes;
  idx_res_t          idx_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign oversized = !in_is_end && (32'(in_pair_count) > 32'(MAX_PAIRS));
  assign idx_base  = seen_r ? exp_r : in_record_index;
  assign idx_start = accept && !closed_r && !oversized;
  assign crc_bytes = BYTE_W'({cnt_r, {PAIR_SHIFT{1'b0}}});

  rsc_idx_serial u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .a_in  (in_record_index),
    .b_in  (idx_base),
    .c_in  (in_pair_count),
    .res   (idx_res),
    .diff  (idx_diff),
    .sum   (idx_sum)
  );

  rsc_crc_shift #(
    .BYTE_W (BYTE_W)
  ) u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (crc_start),
    .crc_in  (crc_r),
    .nbytes  (crc_bytes),
    .done    (crc_done),
    .crc_out (crc_shifted)
  );

  always_comb begin
    state_nxt      = state_r;
    exp_nxt        = exp_r;
    crc_nxt        = crc_r;
    gap_nxt        = gap_r;
    seen_nxt       = seen_r;
    closed_nxt     = closed_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    rcrc_nxt       = rcrc_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_fill_nxt   = res_fill_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    out_crc_nxt    = out_crc_r;
    out_next_nxt   = out_next_r;
    out_gap_nxt    = out_gap_r;
    crc_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt      = in_record_index;
          cnt_nxt      = in_pair_count;
          rcrc_nxt     = in_record_crc;
          end_nxt      = in_is_end;
          res_fill_nxt = '0;
          if (closed_r) begin
            res_status_nxt = ST_REJECT;
            state_nxt      = S_DONE;
          end else if (oversized) begin
            closed_nxt     = 1'b1;
            res_status_nxt = ST_REJECT;
            state_nxt      = S_DONE;
          end else begin
            seen_nxt  = 1'b1;
            state_nxt = S_IDX;
          end
        end
      end
      S_IDX: begin
        if (idx_res.done) begin
          if (idx_res.below) begin
            closed_nxt     = 1'b1;
            res_status_nxt = ST_BACKWARD;
            state_nxt      = S_DONE;
          end else begin
            if (idx_res.ahead) begin
              res_fill_nxt = idx_diff;
              if (gap_r != '1) begin
                gap_nxt = gap_r + 1'b1;
              end
            end
            if (end_r) begin
              exp_nxt        = idx_r;
              closed_nxt     = 1'b1;
              res_status_nxt = (rcrc_r == crc_r) ? ST_END_OK : ST_END_BAD;
              state_nxt      = S_DONE;
            end else begin
              // The index realigns to this record, so the next one is idx + count.
              exp_nxt        = idx_sum;
              res_status_nxt = idx_res.ahead ? ST_GAP : ST_ACCEPT;
              crc_start      = 1'b1;
              state_nxt      = S_CRC;
            end
          end
        end
      end
      S_CRC: begin
        if (crc_done) begin
          crc_nxt   = crc_shifted ^ rcrc_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fill_nxt   = res_fill_r;
          out_crc_nxt    = crc_r;
          out_next_nxt   = exp_r;
          out_gap_nxt    = gap_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      crc_r       <= '0;
      gap_r       <= '0;
      seen_r      <= 1'b0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      crc_r       <= crc_nxt;
      gap_r       <= gap_nxt;
      seen_r      <= seen_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    rcrc_r       <= rcrc_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_fill_r   <= res_fill_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
    out_crc_r    <= out_crc_nxt;
    out_next_r   <= out_next_nxt;
    out_gap_r    <= out_gap_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fill_pairs = out_fill_r;
  assign out_stream_crc = out_crc_r;
  assign out_next_index = out_next_r;
  assign out_gap_total  = out_gap_r;

  // Once closed, the stream state is frozen.
  a_closed_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> (closed_r && $stable(crc_r) && $stable(exp_r) && $stable(gap_r)))
    else $error("stream state changed after close");

  // The CRC combine only runs for an open stream.
  a_crc_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC) |-> !closed_r)
    else $error("CRC combine running on a closed stream");

  // The gap count never goes down.
  a_gap_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (gap_r >= $past(gap_r)))
    else $error("gap count decreased");

endmodule

`default_nettype wire
